/* hdl/wmt_pkg.sv */
package wmt_pkg;

  // default mask size and limits
  localparam int MASK_POINTS_DEF = 256;
  localparam logic [7:0] LOW_DEF  = 8'd32;
  localparam logic [7:0] HIGH_DEF = 8'(255 - 32);

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // reciprocal of three for sums of up to three 8-bit values
  localparam logic [10:0] RECIP3     = 11'd683;
  localparam int          DIV3_SHIFT = 11;

  typedef enum logic [2:0] {
    OP_SAMPLE,
    OP_CAPTURE,
    OP_DEFAULT,
    OP_EXPAND,
    OP_SHRINK,
    OP_BLUR_OUT,
    OP_BLUR_IN,
    OP_CLEAR_COUNTS
  } op_t;

  typedef enum logic [1:0] {
    FA_NONE,
    FA_BEEP,
    FA_BEEP_STOP,
    FA_STOP
  } fail_act_t;

  typedef enum logic [1:0] {
    CFG_COLLECT,
    CFG_TEST,
    CFG_ACTION
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POINT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_dflt;
    logic point_commit;
    logic result_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_status_t;

  // 3-point neighbor filter, pulls b toward smaller neighbors
  function automatic logic [7:0] nb_filter(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [9:0]  sum3;
    logic [20:0] prod;
    logic [8:0]  sum_ab;
    logic [8:0]  sum_cb;
    logic [7:0]  res;
    sum3   = 10'(a) + 10'(b) + 10'(c);
    prod   = 21'(sum3) * 21'(RECIP3);
    sum_ab = 9'(a) + 9'(b);
    sum_cb = 9'(c) + 9'(b);
    priority if (a < b && c < b) begin
      res = prod[DIV3_SHIFT +: 8];
    end else if (a < b) begin
      res = sum_ab[8:1];
    end else if (c < b) begin
      res = sum_cb[8:1];
    end else begin
      res = b;
    end
    return res;
  endfunction

  // mirrored filter, pulls b toward larger neighbors
  function automatic logic [7:0] nb_filter_inv(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    return ~nb_filter(~a, ~b, ~c);
  endfunction

endpackage

/* hdl/wmt_in_if.sv */
interface wmt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] point_index;
  logic [7:0] sample_value;
  logic       frame_last;

  modport source (
    output valid, operation, point_index, sample_value, frame_last,
    input  ready
  );
  modport sink (
    input  valid, operation, point_index, sample_value, frame_last,
    output ready
  );
endinterface

/* hdl/wmt_out_if.sv */
interface wmt_out_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic        frame_failed;
  logic        beep;
  logic        stop_trigger;
  logic [15:0] pass_count;
  logic [15:0] fail_count;

  modport source (
    output valid, frame_done, frame_failed, beep, stop_trigger, pass_count, fail_count,
    input  ready
  );
  modport sink (
    input  valid, frame_done, frame_failed, beep, stop_trigger, pass_count, fail_count,
    output ready
  );
endinterface

/* hdl/wmt_ctrl.sv */
module wmt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [2:0]             in_operation,
  output logic                   in_ready,
  output wmt_pkg::ctrl_cmd_t     cmd,
  input  wmt_pkg::dp_status_t    status
);
  import wmt_pkg::*;

  state_t state_r;
  state_t state_nxt;
  op_t    in_op;

  assign in_op = op_t'(in_operation);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_SAMPLE, OP_CAPTURE: state_nxt = ST_POINT;
            OP_CLEAR_COUNTS:       state_nxt = ST_DONE;
            default:               state_nxt = ST_SWEEP;
          endcase
        end
      end
      ST_POINT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    in_ready         = (state_r == ST_IDLE);
    cmd.accept       = in_ready && in_valid;
    cmd.sweep        = (state_r == ST_CLEAR) || (state_r == ST_SWEEP);
    cmd.sweep_dflt   = (state_r == ST_CLEAR);
    cmd.point_commit = (state_r == ST_POINT) && status.out_free;
    cmd.result_load  = (state_r == ST_DONE) && status.out_free;
  end

  // a finished sweep always hands over to the result stage
  a_sweep_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && status.sweep_last) |=> (state_r == ST_DONE))
    else $error("sweep end did not reach result stage");

  // single-point operations go through the read-modify-write stage
  a_point_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (in_op == OP_SAMPLE || in_op == OP_CAPTURE)) |=> (state_r == ST_POINT))
    else $error("point operation skipped its stage");

  // a commit always frees the block for the next item
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.point_commit |=> (state_r == ST_IDLE))
    else $error("point commit did not return to idle");

endmodule

/* hdl/wmt_datapath.sv */
module wmt_datapath #(
  parameter int MASK_POINTS = wmt_pkg::MASK_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wmt_pkg::ctrl_cmd_t                cmd,
  output wmt_pkg::dp_status_t               status,
  input  logic [2:0]                        in_operation,
  input  logic [7:0]                        in_point_index,
  input  logic [7:0]                        in_sample_value,
  input  logic                              in_frame_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_frame_done,
  output logic                              out_frame_failed,
  output logic                              out_beep,
  output logic                              out_stop_trigger,
  output logic [15:0]                       out_pass_count,
  output logic [15:0]                       out_fail_count,
  input  logic                              cfg_we,
  input  logic [wmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wmt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wmt_pkg::*;

  localparam int AW = $clog2(MASK_POINTS);
  localparam int CW = $clog2(MASK_POINTS + 1);
  localparam logic [CW-1:0] CNT_END   = CW'(MASK_POINTS);
  localparam logic [AW-1:0] PT_BLUR0  = AW'(2);
  localparam logic [AW-1:0] PT_ONE    = AW'(1);
  localparam logic [AW-1:0] PT_LAST   = AW'(MASK_POINTS - 1);

  // mask memory, one word per point: {low, high}
  logic [15:0] mem [MASK_POINTS];
  logic [15:0] rd_data_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_data;

  // latched item
  op_t        op_r;
  logic [7:0] idx_r;
  logic [7:0] smp_r;
  logic       last_r;

  // configuration
  logic      collect_r;
  logic      test_r;
  fail_act_t fail_act_r;

  // sweep
  logic [CW-1:0] cnt_r;
  logic          sw_vld_r;
  logic [AW-1:0] rd_pt_r;
  logic [15:0]   w0_r;
  logic [15:0]   w1_r;
  logic          sweep_rd;
  op_t           sw_mode;

  // frame state and counters
  logic        flag_r;
  logic [15:0] pass_r;
  logic [15:0] fail_r;

  // result register
  logic        out_vld_r;
  logic        done_r;
  logic        failed_r;
  logic        beep_r;
  logic        stop_r;
  logic [15:0] pcnt_r;
  logic [15:0] fcnt_r;

  // point path
  logic       in_range;
  logic       testing;
  logic       is_sample;
  logic [7:0] old_low;
  logic [7:0] old_high;
  logic [7:0] new_low;
  logic [7:0] new_high;
  logic       flag_acc;
  logic       verdict;
  logic       v_fail;
  logic       v_pass;
  logic       beep_v;
  logic       stop_v;
  logic [15:0] pass_inc;
  logic [15:0] fail_inc;
  logic        clear_cnt;

  // sweep arithmetic
  logic [7:0] exp_low;
  logic [7:0] exp_high;
  logic [7:0] shr_low;
  logic [7:0] shr_high;
  logic [7:0] bo_low;
  logic [7:0] bo_high;
  logic [7:0] bi_low;
  logic [7:0] bi_high;

  // read port control
  always_comb begin
    sweep_rd = cmd.sweep && (cnt_r != CNT_END);
    rd_en    = cmd.accept || sweep_rd;
    rd_addr  = cmd.accept ? AW'(in_point_index) : cnt_r[AW-1:0];
    sw_mode  = cmd.sweep_dflt ? OP_DEFAULT : op_r;
  end

  // point compare and frame verdict
  always_comb begin
    in_range  = (32'(idx_r) < 32'(MASK_POINTS));
    testing   = test_r || (fail_act_r != FA_NONE);
    is_sample = (op_r == OP_SAMPLE);
    old_low   = rd_data_r[15:8];
    old_high  = rd_data_r[7:0];
    new_low   = (collect_r && smp_r < old_low) ? smp_r : old_low;
    new_high  = (collect_r && smp_r > old_high) ? smp_r : old_high;
    flag_acc  = flag_r || (in_range && testing && (smp_r < new_low || smp_r > new_high));
    verdict   = is_sample && last_r && testing;
    v_fail    = verdict && flag_acc;
    v_pass    = verdict && !flag_acc;
    beep_v    = v_fail && (fail_act_r == FA_BEEP || fail_act_r == FA_BEEP_STOP);
    stop_v    = v_fail && (fail_act_r == FA_BEEP_STOP || fail_act_r == FA_STOP);
    pass_inc  = (pass_r != 16'hFFFF) ? pass_r + 16'd1 : pass_r;
    fail_inc  = (fail_r != 16'hFFFF) ? fail_r + 16'd1 : fail_r;
    clear_cnt = cmd.result_load && (op_r == OP_CLEAR_COUNTS);
  end

  // per-point arithmetic for whole-mask operations
  always_comb begin
    exp_low  = (rd_data_r[15:8] != 8'h00) ? rd_data_r[15:8] - 8'd1 : rd_data_r[15:8];
    exp_high = (rd_data_r[7:0] != 8'hFF) ? rd_data_r[7:0] + 8'd1 : rd_data_r[7:0];
    shr_low  = (rd_data_r[15:8] != 8'hFF && rd_data_r[15:8] < rd_data_r[7:0]) ?
               rd_data_r[15:8] + 8'd1 : rd_data_r[15:8];
    shr_high = (rd_data_r[7:0] != 8'h00 && rd_data_r[7:0] > shr_low) ?
               rd_data_r[7:0] - 8'd1 : rd_data_r[7:0];
    bo_low   = nb_filter(w0_r[15:8], w1_r[15:8], rd_data_r[15:8]);
    bo_high  = nb_filter_inv(w0_r[7:0], w1_r[7:0], rd_data_r[7:0]);
    bi_low   = nb_filter_inv(w0_r[15:8], w1_r[15:8], rd_data_r[15:8]);
    bi_high  = nb_filter(w0_r[7:0], w1_r[7:0], rd_data_r[7:0]);
  end

  // write port mux
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_pt_r;
    wr_data = rd_data_r;
    if (cmd.point_commit) begin
      wr_en   = in_range;
      wr_addr = AW'(idx_r);
      wr_data = (op_r == OP_CAPTURE) ? {smp_r, smp_r} : {new_low, new_high};
    end else if (cmd.sweep && sw_vld_r) begin
      unique case (sw_mode)
        OP_DEFAULT: begin
          wr_en   = 1'b1;
          wr_data = {LOW_DEF, HIGH_DEF};
        end
        OP_EXPAND: begin
          wr_en   = 1'b1;
          wr_data = {exp_low, exp_high};
        end
        OP_SHRINK: begin
          wr_en   = 1'b1;
          wr_data = {shr_low, shr_high};
        end
        OP_BLUR_OUT: begin
          wr_en   = (rd_pt_r >= PT_BLUR0);
          wr_addr = rd_pt_r - PT_ONE;
          wr_data = {bo_low, bo_high};
        end
        OP_BLUR_IN: begin
          wr_en   = (rd_pt_r >= PT_BLUR0);
          wr_addr = rd_pt_r - PT_ONE;
          wr_data = {bi_low, bi_high};
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // mask memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_operation);
      idx_r  <= in_point_index;
      smp_r  <= in_sample_value;
      last_r <= in_frame_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collect_r  <= 1'b0;
      test_r     <= 1'b0;
      fail_act_r <= FA_NONE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLLECT: collect_r  <= cfg_data[0];
        CFG_TEST:    test_r     <= cfg_data[0];
        CFG_ACTION:  fail_act_r <= fail_act_t'(cfg_data[1:0]);
        default:     ;
      endcase
    end
  end

  // sweep counter and read-data tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sw_vld_r <= 1'b0;
    end else begin
      sw_vld_r <= sweep_rd;
      if (cmd.sweep) begin
        cnt_r <= status.sweep_last ? '0 : cnt_r + CW'(1);
      end
    end
  end

  // point number of read data and blur window of old values
  always_ff @(posedge clk) begin
    if (sweep_rd) rd_pt_r <= cnt_r[AW-1:0];
    if (cmd.sweep && sw_vld_r) begin
      w0_r <= w1_r;
      w1_r <= rd_data_r;
    end
  end

  // frame flag and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      pass_r <= '0;
      fail_r <= '0;
    end else if (cmd.point_commit && is_sample) begin
      flag_r <= last_r ? 1'b0 : flag_acc;
      if (v_pass) pass_r <= pass_inc;
      if (v_fail) fail_r <= fail_inc;
    end else if (clear_cnt) begin
      pass_r <= '0;
      fail_r <= '0;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.point_commit || cmd.result_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.point_commit) begin
      done_r   <= verdict;
      failed_r <= v_fail;
      beep_r   <= beep_v;
      stop_r   <= stop_v;
      pcnt_r   <= v_pass ? pass_inc : pass_r;
      fcnt_r   <= v_fail ? fail_inc : fail_r;
    end else if (cmd.result_load) begin
      done_r   <= 1'b0;
      failed_r <= 1'b0;
      beep_r   <= 1'b0;
      stop_r   <= 1'b0;
      pcnt_r   <= clear_cnt ? '0 : pass_r;
      fcnt_r   <= clear_cnt ? '0 : fail_r;
    end
  end

  always_comb begin
    status.sweep_last = (cnt_r == CNT_END);
    status.out_free   = !out_vld_r || out_ready;
  end

  assign out_valid        = out_vld_r;
  assign out_frame_done   = done_r;
  assign out_frame_failed = failed_r;
  assign out_beep         = beep_r;
  assign out_stop_trigger = stop_r;
  assign out_pass_count   = pcnt_r;
  assign out_fail_count   = fcnt_r;

  // a result is only loaded into a free slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.point_commit || cmd.result_load) |-> status.out_free)
    else $error("result loaded over a pending transfer");

  // every commit presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.point_commit |=> out_vld_r)
    else $error("commit did not present a result");

  // the sweep counter rewinds for the next sweep
  a_cnt_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep && status.sweep_last) |=> (cnt_r == '0))
    else $error("sweep counter did not rewind");

  // blur never touches the end points
  a_blur_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && cmd.sweep && (sw_mode == OP_BLUR_OUT || sw_mode == OP_BLUR_IN))
      |-> (wr_addr != '0 && wr_addr != PT_LAST))
    else $error("blur wrote an end point");

endmodule

/* hdl/waveform_mask_tester.sv */
// Pass/fail mask tester: a low/high limit pair per mask point sits in one memory with
// a read port and a write port. Sample and capture items are a memory read, then a
// read-modify-write, and the next item is taken while the previous result still
// waits on the output register. Default, expand, shrink and both blurs sweep the
// memory one point per cycle. After reset the block writes the default limits
// (32 low, 223 high) with in_ch.ready low; configuration writes are taken
// throughout and are meant to be done while the block is idle.
module waveform_mask_tester #(
  parameter int MASK_POINTS = wmt_pkg::MASK_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wmt_in_if.sink                         in_ch,
  wmt_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [wmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wmt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  wmt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .status       (status)
  );

  // mask memory, compare and counters
  wmt_datapath #(
    .MASK_POINTS (MASK_POINTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_ch.operation),
    .in_point_index   (in_ch.point_index),
    .in_sample_value  (in_ch.sample_value),
    .in_frame_last    (in_ch.frame_last),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_frame_done   (out_ch.frame_done),
    .out_frame_failed (out_ch.frame_failed),
    .out_beep         (out_ch.beep),
    .out_stop_trigger (out_ch.stop_trigger),
    .out_pass_count   (out_ch.pass_count),
    .out_fail_count   (out_ch.fail_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule
